// File: hdl/nla_pkg.sv
// Package for the nearest landmark association block: sizes, codes and the
// structs shared by the top level and the distance pipeline.
// Depends on nothing.
package nla_pkg;

   // Table size and coordinate precision.
   localparam int MAX_MARKS  = 64;
   localparam int COORD_BITS = 24;

   // Field widths fixed by the stream format.
   localparam int POS_W  = 24;
   localparam int TAG_W  = 16;
   localparam int DIST_W = 50;

   // Derived widths.
   localparam int ADDR_W = (MAX_MARKS > 1) ? $clog2(MAX_MARKS) : 1;
   localparam int CNT_W  = $clog2(MAX_MARKS + 1);
   localparam int DIFF_W = COORD_BITS + 1;
   localparam int SQ_W   = 2 * DIFF_W;
   localparam int SUM_W  = SQ_W + 1;

   // Stream payload widths.
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 72;
   localparam int RSP_PAD_W  = RSP_DATA_W - DIST_W - TAG_W;

   // Request kinds carried in tuser.
   typedef enum logic [1:0] {
      ACT_CLEAR = 2'd0,
      ACT_LOAD  = 2'd1,
      ACT_QUERY = 2'd2
   } nla_action_type;

   // Control sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT
   } nla_state_type;

   // One landmark table entry.
   typedef struct packed {
      logic [TAG_W-1:0]             tag;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] x;
   } nla_mark_type;

   // Markers travelling with each entry read during a scan.
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } nla_scan_type;

   // Outcome of one completed scan.
   typedef struct packed {
      logic              done;
      logic              found;
      logic [TAG_W-1:0]  tag;
      logic [DIST_W-1:0] dist_sq;
   } nla_result_type;

endpackage

// File: hdl/nearest_landmark_association.sv
// Top level of the nearest landmark association block: request decode, the
// landmark memory, scan sequencer and result register.
// Depends on nla_pkg and nla_dist.
//
//   Channel  Direction  tuser          tdata
//   req      in         action [1:0]   pos_x [23:0], pos_y [47:24], tag [63:48]
//   rsp      out        found [0]      matched_tag [15:0], best_dist_sq [65:16], zeros
//
// Clear and load requests are taken while the sequencer is idle. A query
// result passes the single read port of the landmark memory, which walks the
// stored entries one per cycle, then the three distance stages, the pending
// result register and the output register. A query on an empty table skips
// the scan and answers with found clear. Reset is synchronous and empties the
// table. A stalled result waits in the output register while clear and load
// requests are still taken; a further query scans and then waits for the slot.
module nearest_landmark_association (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [1:0]                         req_tuser,   // action
   input  logic [nla_pkg::REQ_DATA_W-1:0]     req_tdata,   // pos_x, pos_y, tag
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic                               rsp_tuser,   // found
   output logic [nla_pkg::RSP_DATA_W-1:0]     rsp_tdata    // matched_tag, best_dist_sq, zeros
);

   // Request fields.
   logic                                   req_accept;
   logic [nla_pkg::POS_W-1:0]              req_pos_x;
   logic [nla_pkg::POS_W-1:0]              req_pos_y;
   logic [nla_pkg::TAG_W-1:0]              req_tag;
   logic                                   is_clear;
   logic                                   is_load;
   logic                                   is_query;

   // Sequencer.
   nla_pkg::nla_state_type                 state_ff;
   nla_pkg::nla_state_type                 state_in;
   logic [nla_pkg::CNT_W-1:0]              count_ff;
   logic [nla_pkg::CNT_W-1:0]              count_in;
   logic [nla_pkg::ADDR_W-1:0]             idx_ff;
   logic [nla_pkg::ADDR_W-1:0]             idx_in;
   logic [nla_pkg::ADDR_W-1:0]             last_idx;
   logic                                   table_full;
   logic                                   rsp_free;
   logic                                   rd_en;
   logic                                   load_rsp;
   nla_pkg::nla_scan_type                  scan;

   // Landmark memory.
   nla_pkg::nla_mark_type                  mark_mem [nla_pkg::MAX_MARKS];
   nla_pkg::nla_mark_type                  wr_data;
   nla_pkg::nla_mark_type                  rd_data_ff;
   nla_pkg::nla_scan_type                  rd_scan_ff;

   // Observation and results.
   logic signed [nla_pkg::COORD_BITS-1:0]  obs_x_ff;
   logic signed [nla_pkg::COORD_BITS-1:0]  obs_y_ff;
   nla_pkg::nla_result_type                dist_res;
   logic                                   res_found_ff;
   logic [nla_pkg::TAG_W-1:0]              res_tag_ff;
   logic [nla_pkg::DIST_W-1:0]             res_dist_ff;
   logic                                   rsp_valid_ff;
   logic                                   rsp_found_ff;
   logic [nla_pkg::TAG_W-1:0]              rsp_tag_ff;
   logic [nla_pkg::DIST_W-1:0]             rsp_dist_ff;

   // Unpack the request.
   assign req_accept = req_tvalid & req_tready;
   assign req_pos_x  = req_tdata[nla_pkg::POS_W-1:0];
   assign req_pos_y  = req_tdata[2*nla_pkg::POS_W-1:nla_pkg::POS_W];
   assign req_tag    = req_tdata[2*nla_pkg::POS_W+nla_pkg::TAG_W-1:2*nla_pkg::POS_W];

   // Decode the request kind; the unused code does nothing.
   always_comb begin
      is_clear = 1'b0;
      is_load  = 1'b0;
      is_query = 1'b0;
      case (nla_pkg::nla_action_type'(req_tuser))
         nla_pkg::ACT_CLEAR: begin
            is_clear = req_accept;
         end
         nla_pkg::ACT_LOAD: begin
            is_load = req_accept;
         end
         nla_pkg::ACT_QUERY: begin
            is_query = req_accept;
         end
         default: begin
            is_clear = 1'b0;
         end
      endcase
   end

   assign table_full = (count_ff >= nla_pkg::CNT_W'(nla_pkg::MAX_MARKS));
   assign last_idx   = nla_pkg::ADDR_W'(count_ff - 1'b1);
   assign rsp_free   = ~rsp_valid_ff | rsp_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         nla_pkg::ST_IDLE: begin
            if (is_query) begin
               state_in = (count_ff == '0) ? nla_pkg::ST_EMIT : nla_pkg::ST_SCAN;
            end
         end
         nla_pkg::ST_SCAN: begin
            if (idx_ff == last_idx) begin
               state_in = nla_pkg::ST_DRAIN;
            end
         end
         nla_pkg::ST_DRAIN: begin
            if (dist_res.done) begin
               state_in = nla_pkg::ST_EMIT;
            end
         end
         nla_pkg::ST_EMIT: begin
            if (rsp_free) begin
               state_in = nla_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = nla_pkg::ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_tready = 1'b0;
      rd_en      = 1'b0;
      load_rsp   = 1'b0;
      case (state_ff)
         nla_pkg::ST_IDLE: begin
            req_tready = 1'b1;
         end
         nla_pkg::ST_SCAN: begin
            rd_en = 1'b1;
         end
         nla_pkg::ST_DRAIN: begin
            rd_en = 1'b0;
         end
         nla_pkg::ST_EMIT: begin
            load_rsp = rsp_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   assign scan.valid = rd_en;
   assign scan.first = (idx_ff == '0);
   assign scan.last  = (idx_ff == last_idx);

   // Table fill count and scan index.
   always_comb begin
      count_in = count_ff;
      if (is_clear) begin
         count_in = '0;
      end else if (is_load && !table_full) begin
         count_in = count_ff + 1'b1;
      end
      idx_in = rd_en ? idx_ff + 1'b1 : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= nla_pkg::ST_IDLE;
         count_ff   <= '0;
         idx_ff     <= '0;
         rd_scan_ff <= '0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         idx_ff     <= idx_in;
         rd_scan_ff <= scan;
      end
   end

   // Landmark memory: loads write at the fill count, scans read at the index.
   assign wr_data.tag = req_tag;
   assign wr_data.x   = req_pos_x[nla_pkg::COORD_BITS-1:0];
   assign wr_data.y   = req_pos_y[nla_pkg::COORD_BITS-1:0];

   always_ff @(posedge clock) begin
      if (is_load && !table_full) begin
         mark_mem[count_ff[nla_pkg::ADDR_W-1:0]] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mark_mem[idx_ff];
      end
   end

   // Observation held for the whole scan.
   always_ff @(posedge clock) begin
      if (is_query) begin
         obs_x_ff <= req_pos_x[nla_pkg::COORD_BITS-1:0];
         obs_y_ff <= req_pos_y[nla_pkg::COORD_BITS-1:0];
      end
   end

   nla_dist u_dist (
      .clock  (clock),
      .reset  (reset),
      .scan   (rd_scan_ff),
      .mark   (rd_data_ff),
      .obs_x  (obs_x_ff),
      .obs_y  (obs_y_ff),
      .result (dist_res)
   );

   // Pending result: empty-table answer or the outcome of the scan.
   always_ff @(posedge clock) begin
      if (is_query && count_ff == '0) begin
         res_found_ff <= 1'b0;
         res_tag_ff   <= '0;
         res_dist_ff  <= '0;
      end else if (state_ff == nla_pkg::ST_DRAIN && dist_res.done) begin
         res_found_ff <= dist_res.found;
         res_tag_ff   <= dist_res.tag;
         res_dist_ff  <= dist_res.dist_sq;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_found_ff <= res_found_ff;
         rsp_tag_ff   <= res_tag_ff;
         rsp_dist_ff  <= res_dist_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {{nla_pkg::RSP_PAD_W{1'b0}}, rsp_dist_ff, rsp_tag_ff};

`ifndef SYNTHESIS
   // The fill count never passes the table size.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= nla_pkg::CNT_W'(nla_pkg::MAX_MARKS))
      else $error("landmark count beyond table size");

   // The table does not change while a scan walks it.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == nla_pkg::ST_SCAN |=> $stable(count_ff))
      else $error("landmark count changed during a scan");

   // The distance pipeline finishes only while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      dist_res.done |-> state_ff == nla_pkg::ST_DRAIN)
      else $error("scan finished outside the drain state");

   // A new result appears only from the emit state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == nla_pkg::ST_EMIT)
      else $error("result raised outside the emit state");
`endif

endmodule

// File: hdl/nla_dist.sv
// Distance pipeline of the nearest landmark association block: difference,
// square, sum and running minimum over the entries of one scan.
// Depends on nla_pkg.
module nla_dist (
   input  logic                                    clock,
   input  logic                                    reset,
   input  nla_pkg::nla_scan_type                   scan,
   input  nla_pkg::nla_mark_type                   mark,
   input  logic signed [nla_pkg::COORD_BITS-1:0]   obs_x,
   input  logic signed [nla_pkg::COORD_BITS-1:0]   obs_y,
   output nla_pkg::nla_result_type                 result
);

   // Stage A: coordinate differences.
   nla_pkg::nla_scan_type                  a_ctl_ff;
   logic signed [nla_pkg::DIFF_W-1:0]      a_dx_ff;
   logic signed [nla_pkg::DIFF_W-1:0]      a_dy_ff;
   logic [nla_pkg::TAG_W-1:0]              a_tag_ff;

   // Stage B: squares.
   nla_pkg::nla_scan_type                  b_ctl_ff;
   logic [nla_pkg::SQ_W-1:0]               b_sqx_ff;
   logic [nla_pkg::SQ_W-1:0]               b_sqy_ff;
   logic [nla_pkg::TAG_W-1:0]              b_tag_ff;

   // Stage C: running best.
   logic [nla_pkg::SUM_W-1:0]              sum;
   logic                                   take;
   logic [nla_pkg::SUM_W-1:0]              best_ff;
   logic [nla_pkg::TAG_W-1:0]              best_tag_ff;
   logic                                   done_ff;

   // Control markers follow the data down the pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff <= '0;
         b_ctl_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         a_ctl_ff <= scan;
         b_ctl_ff <= a_ctl_ff;
         done_ff  <= b_ctl_ff.valid & b_ctl_ff.last;
      end
   end

   // Differences are one bit wider than the coordinates, so they cannot overflow.
   always_ff @(posedge clock) begin
      a_dx_ff  <= nla_pkg::DIFF_W'(mark.x) - nla_pkg::DIFF_W'(obs_x);
      a_dy_ff  <= nla_pkg::DIFF_W'(mark.y) - nla_pkg::DIFF_W'(obs_y);
      a_tag_ff <= mark.tag;
   end

   // A signed square is never negative, so it is kept as an unsigned value.
   always_ff @(posedge clock) begin
      b_sqx_ff <= a_dx_ff * a_dx_ff;
      b_sqy_ff <= a_dy_ff * a_dy_ff;
      b_tag_ff <= a_tag_ff;
   end

   // Only a strictly smaller distance replaces the best, so the earliest entry
   // wins a tie.
   assign sum  = {1'b0, b_sqx_ff} + {1'b0, b_sqy_ff};
   assign take = b_ctl_ff.valid & (b_ctl_ff.first | (sum < best_ff));

   always_ff @(posedge clock) begin
      if (take) begin
         best_ff     <= sum;
         best_tag_ff <= b_tag_ff;
      end
   end

   assign result.done    = done_ff;
   assign result.found   = 1'b1;
   assign result.tag     = best_tag_ff;
   assign result.dist_sq = nla_pkg::DIST_W'(best_ff);

endmodule
